[rtl/sbus_frame_decoder_unit_defines.svh]
// assertion macros for the sbus frame decoder checker
`ifndef SBUS_FRAME_DECODER_UNIT_DEFINES_SVH
`define SBUS_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sbus_fd_pkg.sv]
// shared constants, codes and types of the sbus frame decoder
package sbus_fd_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int FRAME_LEN    = 25;
  localparam int POS_W        = $clog2(FRAME_LEN);
  localparam int BYTE_W       = 8;
  localparam int CHAN_W       = 11;
  localparam int IDX_W        = 4;
  localparam int ACC_W        = CHAN_W - 1 + BYTE_W;
  localparam int CNT_W        = $clog2(ACC_W + 1);

  localparam logic [POS_W-1:0] END_POS     = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] FIRST_DATA  = POS_W'(1);
  localparam logic [IDX_W-1:0] LAST_CHAN   = IDX_W'(NUM_CHANNELS - 1);

  typedef enum logic [0:0] {
    REG_START_BYTE = 1'b0,
    REG_END_BYTE   = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    KIND_STATUS  = 1'b0,
    KIND_CHANNEL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_NO_SYNC  = 2'd1,
    ST_BAD_END  = 2'd2
  } status_t;

  // sequencer to unpacker
  typedef struct packed {
    logic clear;
    logic rd_step;
    logic merge;
    logic take;
  } unpack_ctl_t;

  // unpacker to sequencer
  typedef struct packed {
    logic              fill_on_merge;
    logic [CHAN_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              is_last;
  } unpack_stat_t;

endpackage

[rtl/sbus_fd_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
module sbus_fd_ram #(
  parameter int DEPTH = 25,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/sbus_fd_unpack.sv]
// bit buffer that slices stored frame bytes into 11-bit channel values
module sbus_fd_unpack
  import sbus_fd_pkg::*;
(
  input  logic                clk,
  input  unpack_ctl_t         ctl,
  input  logic [BYTE_W-1:0]   rd_data,
  output logic [POS_W-1:0]    rd_addr,
  output unpack_stat_t        stat
);

  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] chan;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      rd_addr <= FIRST_DATA;
      acc     <= '0;
      cnt     <= '0;
      chan    <= '0;
    end else begin
      if (ctl.rd_step) begin
        rd_addr <= rd_addr + POS_W'(1);
      end
      if (ctl.merge) begin
        acc <= acc | (ACC_W'(rd_data) << cnt);
        cnt <= cnt + CNT_W'(BYTE_W);
      end else if (ctl.take) begin
        acc  <= acc >> CHAN_W;
        cnt  <= cnt - CNT_W'(CHAN_W);
        chan <= chan + IDX_W'(1);
      end
    end
  end

  // one more byte completes a channel once three bits are waiting
  assign stat.fill_on_merge = (cnt >= CNT_W'(CHAN_W - BYTE_W));
  assign stat.value         = acc[CHAN_W-1:0];
  assign stat.index         = chan;
  assign stat.is_last       = (chan == LAST_CHAN);

endmodule

[rtl/sbus_frame_decoder_unit.sv]
// sbus frame decoder top level: byte intake, frame store, channel readout
// Takes one received byte per request and builds 25-byte sbus frames in a
// small synchronous frame store. Every byte gives one status result: accepted,
// out of sync start (a byte other than start_byte while no frame is open) or
// bad end byte (byte 24 differs from end_byte). A byte that closes a valid
// frame gives its status result with last low, then sixteen channel results,
// channel 0 first, the final one with last high. An ordinary byte is taken
// when the result register is free. After a valid frame end the readout
// steps through the stored bytes one at a time over the single read port,
// each in an address step and then a merge into the bit buffer, with a
// channel result step per complete channel. No byte is taken during the
// readout, so reads and writes of the frame store never overlap. start_byte
// resets to 0x0f and end_byte to 0x00; write them only while the block is idle.
module sbus_frame_decoder_unit
  import sbus_fd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_en,
  input  logic [0:0]          cfg_index,
  input  logic [BYTE_W-1:0]   cfg_data,
  // received byte requests
  input  logic                rx_valid,
  output logic                rx_stall,
  input  logic [BYTE_W-1:0]   rx_byte,
  // result requests
  output logic                res_valid,
  input  logic                res_stall,
  output logic                kind,
  output logic [1:0]          status,
  output logic [IDX_W-1:0]    channel_index,
  output logic [CHAN_W-1:0]   channel_value,
  output logic                last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MERGE,
    S_EMIT
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;
  logic [POS_W-1:0]  byte_position;

  logic              out_free;
  logic              res_load;
  logic              rx_take;
  logic              no_sync;
  logic              at_end;
  logic              frame_ok;
  logic              store_wr;
  logic [POS_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  unpack_ctl_t       ctl;
  unpack_stat_t      stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'h0f;
      end_byte   <= 8'h00;
    end else if (cfg_en) begin
      case (reg_index_t'(cfg_index))
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // result register can take a new result this cycle
  assign out_free = !res_valid || !res_stall;

  // bytes are only taken while idle and with room for the status result
  assign rx_stall = (state != S_IDLE) || !out_free;
  assign rx_take  = rx_valid && !rx_stall;

  // a new result enters the result register
  assign res_load = rx_take || ((state == S_EMIT) && out_free);

  // byte classification
  assign no_sync  = (byte_position == '0) && (rx_byte != start_byte);
  assign at_end   = (byte_position == END_POS);
  assign frame_ok = rx_take && !no_sync && at_end && (rx_byte == end_byte);
  assign store_wr = rx_take && !no_sync;

  // unpacker control, decoded from the sequencer state and the frame end check
  always_comb begin
    ctl         = '0;
    ctl.clear   = frame_ok;
    ctl.rd_step = (state == S_READ);
    ctl.merge   = (state == S_MERGE);
    ctl.take    = (state == S_EMIT) && out_free;
  end

  sbus_fd_ram #(
    .DEPTH (FRAME_LEN),
    .WIDTH (BYTE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (byte_position),
    .wr_data (rx_byte),
    .rd_en   (state == S_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbus_fd_unpack u_unpack (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .stat    (stat)
  );

  // sequencer, frame position and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_position <= '0;
      res_valid     <= 1'b0;
    end else begin
      // held while stalled, dropped once taken
      res_valid <= res_load || (res_valid && res_stall);
      case (state)
        S_IDLE: begin
          if (rx_take) begin
            kind          <= KIND_STATUS;
            channel_index <= '0;
            channel_value <= '0;
            // channels follow the status result of a valid frame end
            last          <= !frame_ok;
            if (no_sync) begin
              status <= ST_NO_SYNC;
            end else if (at_end) begin
              byte_position <= '0;
              if (frame_ok) begin
                status <= ST_ACCEPTED;
                state  <= S_READ;
              end else begin
                status <= ST_BAD_END;
              end
            end else begin
              status        <= ST_ACCEPTED;
              byte_position <= byte_position + POS_W'(1);
            end
          end
        end
        S_READ: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          state <= stat.fill_on_merge ? S_EMIT : S_READ;
        end
        S_EMIT: begin
          if (out_free) begin
            kind          <= KIND_CHANNEL;
            status        <= ST_ACCEPTED;
            channel_index <= stat.index;
            channel_value <= stat.value;
            last          <= stat.is_last;
            state         <= stat.is_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/sbus_fd_checker.sv]
// port-level checks of the sbus frame decoder, bound to the top level
`include "sbus_frame_decoder_unit_defines.svh"

module sbus_fd_checker
  import sbus_fd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              rx_stall,
  input logic              res_valid,
  input logic              res_stall,
  input logic              kind,
  input logic [1:0]        status,
  input logic [IDX_W-1:0]  channel_index,
  input logic [CHAN_W-1:0] channel_value,
  input logic              last
);

  `SFD_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
    res_valid && $stable(kind) && $stable(status) && $stable(channel_index) &&
    $stable(channel_value) && $stable(last), "stalled result changed")
  `SFD_ASSERT_NOW(a_chan_status, res_valid && (kind == KIND_CHANNEL),
    status == ST_ACCEPTED, "channel result with nonzero status")
  `SFD_ASSERT_NOW(a_err_last, res_valid && (kind == KIND_STATUS) && (status != ST_ACCEPTED),
    last, "error status not final")
  `SFD_ASSERT_NOW(a_busy_stall, res_valid && !last, rx_stall,
    "byte taken during channel readout")

endmodule

bind sbus_frame_decoder_unit sbus_fd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_stall      (rx_stall),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .kind          (kind),
  .status        (status),
  .channel_index (channel_index),
  .channel_value (channel_value),
  .last          (last)
);

[bench/tb.sv]
// self-checking bench for the sbus frame decoder: byte requests in, status and channel results out
module tb;
  import sbus_fd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one result request as the block should present it
  typedef struct {
    kind_t             kind;
    status_t           status;
    logic [IDX_W-1:0]  index;
    logic [CHAN_W-1:0] value;
    logic              last;
  } result_t;

  // clock, reset and every input start at a known value
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_en = 1'b0;
  logic [0:0] cfg_index = REG_START_BYTE;
  logic [BYTE_W-1:0] cfg_data = '0;
  logic rx_valid = 1'b0;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic res_stall = 1'b0;

  logic rx_stall;
  logic res_valid;
  logic kind;
  logic [1:0] status;
  logic [IDX_W-1:0] channel_index;
  logic [CHAN_W-1:0] channel_value;
  logic last;

  // shadow of the block: registers, frame bytes and write position
  logic [BYTE_W-1:0] start_cfg = 8'h0f;
  logic [BYTE_W-1:0] end_cfg = 8'h00;
  logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
  logic [POS_W-1:0] frame_pos = '0;

  // results still owed by the block, oldest first
  result_t due_results [$];
  result_t want;

  // idling knobs, in percent per cycle
  int send_pct = 0;
  int stall_pct = 0;

  int errors = 0;
  int n_bytes = 0;
  int n_frames = 0;
  int n_bad_end = 0;
  int n_no_sync = 0;

  sbus_frame_decoder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_en        (cfg_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last          (last)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // work out what one accepted byte should produce and queue it
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    logic [183:0] flat;
    n_bytes++;
    r.kind   = KIND_STATUS;
    r.status = ST_ACCEPTED;
    r.index  = '0;
    r.value  = '0;
    r.last   = 1'b1;
    // no frame open and the byte is not the opener: dropped
    if (frame_pos == '0 && b != start_cfg) begin
      r.status = ST_NO_SYNC;
      n_no_sync++;
      due_results.push_back(r);
      return;
    end
    frame_bytes[frame_pos] = b;
    if (frame_pos != END_POS) begin
      frame_pos++;
      due_results.push_back(r);
      return;
    end
    // frame complete, position wraps whatever the closing byte
    frame_pos = '0;
    if (b != end_cfg) begin
      r.status = ST_BAD_END;
      n_bad_end++;
      due_results.push_back(r);
      return;
    end
    n_frames++;
    r.last = 1'b0;
    due_results.push_back(r);
    // channels are packed lsb first from byte 1 onwards
    for (int i = 1; i < FRAME_LEN - 1; i++) flat[(i-1)*8 +: 8] = frame_bytes[i];
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      r.kind  = KIND_CHANNEL;
      r.index = IDX_W'(ch);
      r.value = flat[ch*CHAN_W +: CHAN_W];
      r.last  = (ch == NUM_CHANNELS - 1);
      due_results.push_back(r);
    end
  endtask

  // result checker: every accepted result against the oldest one owed
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing owed: kind %0d status %0d ch %0d val %0d last %0d",
                 $time, kind, status, channel_index, channel_value, last);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (kind !== want.kind || status !== want.status || channel_index !== want.index ||
            channel_value !== want.value || last !== want.last) begin
          $display("%0t: mismatch: expected kind %0d status %0d ch %0d val %0d last %0d",
                   $time, want.kind, want.status, want.index, want.value, want.last);
          $display("%0t:           actual   kind %0d status %0d ch %0d val %0d last %0d",
                   $time, kind, status, channel_index, channel_value, last);
          errors++;
        end
      end
    end
  end

  // one byte request: optional idle cycles, then hold until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    decode_byte(b);
  endtask

  // stop sending and let every owed result come out, plus a short margin
  task automatic wait_drained();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input reg_index_t idx, input logic [BYTE_W-1:0] val);
    wait_drained();
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_en <= 1'b0;
    if (idx == REG_START_BYTE) start_cfg = val;
    else end_cfg = val;
  endtask

  function automatic logic [183:0] random_payload();
    logic [183:0] p;
    for (int i = 0; i < 23; i++) p[i*8 +: 8] = 8'($urandom_range(255));
    return p;
  endfunction

  // full frame: opener, 23 payload bytes, closing byte
  // if an earlier stray opener left a frame half built, pad it out first
  task automatic send_frame(input logic [183:0] payload, input logic [BYTE_W-1:0] closing);
    while (frame_pos != '0) send_byte(8'($urandom_range(255)));
    send_byte(start_cfg);
    for (int i = 0; i < 23; i++) send_byte(payload[i*8 +: 8]);
    send_byte(closing);
  endtask

  // bytes other than the reset opener while no frame is open
  task automatic test_out_of_sync();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h0e);
    send_byte(8'h10);
    send_byte(8'h8f);
  endtask

  // valid frame with channels alternating between the two extremes
  task automatic test_channel_extremes();
    logic [183:0] p;
    p = '0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++)
      p[ch*CHAN_W +: CHAN_W] = (ch % 2) ? 11'h7ff : 11'h000;
    p[183:176] = 8'h5a;
    send_frame(p, end_cfg);
  endtask

  // closing byte differs from the reset end byte
  task automatic test_bad_end();
    send_frame(random_payload(), 8'hff);
  endtask

  // one phase of mostly well-formed frames with random content,
  // some broken closings and some stray bytes
  task automatic run_traffic_phase(input int s_pct, input int r_pct,
                                   input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] eb,
                                   input bit hold_off);
    int first;
    int pick;
    bit held;
    held = 1'b0;
    write_reg(REG_START_BYTE, sb);
    write_reg(REG_END_BYTE, eb);
    send_pct  = s_pct;
    stall_pct = r_pct;
    first = n_bytes;
    while (n_bytes - first < 30) begin
      pick = $urandom_range(99);
      if (pick < 65) send_frame(random_payload(), end_cfg);
      else if (pick < 80) send_frame(random_payload(), end_cfg ^ 8'($urandom_range(1, 255)));
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      // with hold_off, the sender holds back once until every owed result has come out
      if (hold_off && !held && n_bytes - first >= 20) begin
        wait_drained();
        held = 1'b1;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 8'h00, 8'hff, 1'b0);
    run_traffic_phase(78, 0, 8'hff, 8'h00, 1'b1);
    run_traffic_phase(0, 78, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    run_traffic_phase(11, 11, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    // reset held from the start, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part runs on the reset register values
    test_out_of_sync();
    test_channel_extremes();
    test_bad_end();
    test_random_traffic();

    // drain, then give the readout time to show any stray result
    wait_drained();
    repeat (70) @(posedge clk);
    $display("tb: %0d byte requests, %0d frames decoded, %0d bad end bytes, %0d out of sync",
             n_bytes, n_frames, n_bad_end, n_no_sync);
    $display("tb: register extremes and random settings, four idle and stall mixes");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/sbus_fd_pkg.sv
rtl/sbus_fd_ram.sv
rtl/sbus_fd_unpack.sv
rtl/sbus_frame_decoder_unit.sv
rtl/sbus_fd_checker.sv
bench/tb.sv
